// File: hw/rtl/sat_pkg.sv
package sat_pkg;

    // table geometry
    localparam int MAX_ALARMS = 16;
    localparam int ADDR_W     = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CNT_W      = $clog2(MAX_ALARMS + 1);

    // field widths
    localparam int KIND_W   = 2;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;
    localparam int SLOT_W   = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;
    localparam int KEY_W    = HOUR_W + MINUTE_W;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CHECK  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_READ   = 2'd3
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_DUP       = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_BAD_INDEX = 2'd3
    } status_t;

    // one access to the entry memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [KEY_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    // one finished result from the sequencer
    typedef struct packed {
        logic                valid;
        logic                fire;
        logic [COUNT_W-1:0]  alarm_count;
        status_t             status;
        logic [HOUR_W-1:0]   entry_hour;
        logic [MINUTE_W-1:0] entry_minute;
    } result_t;

endpackage

// File: hw/rtl/sorted_alarm_time_table.sv
// channel | dir | handshake          | payload
// s_*     | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata hour, minute, second, slot
// m_*     | out | m_tvalid/m_tready  | m_tdata fire, alarm_count, status, entry_hour, entry_minute
//
// one request at a time: time check and insert first search the table, a read and a
// compare per stored entry, an insert then moves larger entries up; delete moves
// entries down; read fetches the addressed entry; all through the entry memory
// with its registered read port
// reset clears the sequencer state, the alarm count and the output valid; entry memory contents are never cleared
// a finished result waits in the output register while the next request is taken in
module sorted_alarm_time_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hour[4:0], minute[10:5], second[16:11], slot[20:17]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // fire[0], alarm_count[5:1], status[7:6],
                                   // entry_hour[12:8], entry_minute[18:13]
);

    sat_pkg::mem_req_t                 mem_req;
    logic [sat_pkg::KEY_W-1:0]         mem_rdata;
    sat_pkg::result_t                  result;
    logic                              result_take;
    logic [sat_pkg::KEY_W-1:0]         in_key;
    logic                              out_valid_reg;
    logic [23:0]                       out_data_reg;

    // request unpacking, key is {hour, minute}
    assign in_key = {s_tdata[4:0], s_tdata[10:5]};

    sat_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (sat_pkg::kind_t'(s_tuser)),
        .in_key      (in_key),
        .in_second   (s_tdata[16:11]),
        .in_slot     (s_tdata[20:17]),
        .mem_req     (mem_req),
        .mem_rdata   (mem_rdata),
        .result      (result),
        .result_take (result_take)
    );

    sat_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    // output register
    assign result_take = result.valid && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_take)
        begin
            out_data_reg <= {5'b0, result.entry_minute, result.entry_hour, result.status,
                             result.alarm_count, result.fire};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: hw/rtl/sat_mem.sv
module sat_mem
(
    input  logic                         clk,
    input  sat_pkg::mem_req_t            req,
    output logic [sat_pkg::KEY_W-1:0]    rdata
);

    logic [sat_pkg::KEY_W-1:0] mem [sat_pkg::MAX_ALARMS];
    logic [sat_pkg::KEY_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/sat_ctrl.sv
module sat_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    // request side
    input  logic                           in_valid,
    output logic                           in_ready,
    input  sat_pkg::kind_t                 in_kind,
    input  logic [sat_pkg::KEY_W-1:0]      in_key,
    input  logic [sat_pkg::SECOND_W-1:0]   in_second,
    input  logic [sat_pkg::SLOT_W-1:0]     in_slot,
    // memory side
    output sat_pkg::mem_req_t              mem_req,
    input  logic [sat_pkg::KEY_W-1:0]      mem_rdata,
    // result side
    output sat_pkg::result_t               result,
    input  logic                           result_take
);

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SCAN_RD  = 9'b000000010,
        ST_SCAN_CMP = 9'b000000100,
        ST_INS_RD   = 9'b000001000,
        ST_INS_WR   = 9'b000010000,
        ST_DEL_RD   = 9'b000100000,
        ST_DEL_WR   = 9'b001000000,
        ST_RD_WAIT  = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    state_t                          state_reg, state_next;
    logic [sat_pkg::CNT_W-1:0]       total_reg, total_next;
    logic [sat_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic [sat_pkg::ADDR_W-1:0]      ptr_reg, ptr_next;
    logic                            found_reg, found_next;
    sat_pkg::kind_t                  kind_reg, kind_next;
    logic [sat_pkg::KEY_W-1:0]       key_reg, key_next;
    logic                            sec_zero_reg, sec_zero_next;
    logic                            fire_reg, fire_next;
    sat_pkg::status_t                status_reg, status_next;
    logic [sat_pkg::KEY_W-1:0]       entry_reg, entry_next;
    logic [sat_pkg::CNT_W-1:0]       slot_ext;
    logic [sat_pkg::CNT_W-1:0]       ptr_ext;

    assign slot_ext = sat_pkg::CNT_W'(in_slot);
    assign ptr_ext  = sat_pkg::CNT_W'(ptr_reg);

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        total_next    = total_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;
        found_next    = found_reg;
        kind_next     = kind_reg;
        key_next      = key_reg;
        sec_zero_next = sec_zero_reg;
        fire_next     = fire_reg;
        status_next   = status_reg;
        entry_next    = entry_reg;
        mem_req       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = in_kind;
                    key_next      = in_key;
                    sec_zero_next = (in_second == '0);
                    fire_next     = 1'b0;
                    status_next   = sat_pkg::STAT_OK;
                    entry_next    = '0;
                    idx_next      = '0;
                    found_next    = 1'b0;
                    ptr_next      = sat_pkg::ADDR_W'(in_slot);
                    case (in_kind) inside
                        sat_pkg::KIND_CHECK, sat_pkg::KIND_INSERT:
                        begin
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            if (slot_ext >= total_reg)
                            begin
                                status_next = sat_pkg::STAT_BAD_INDEX;
                                state_next  = ST_FINISH;
                            end
                            else if (in_kind == sat_pkg::KIND_DELETE)
                            begin
                                state_next = ST_DEL_RD;
                            end
                            else
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = sat_pkg::ADDR_W'(in_slot);
                                state_next    = ST_RD_WAIT;
                            end
                        end
                    endcase
                end
            end

            // linear search for the key over the stored entries
            ST_SCAN_RD:
            begin
                if (idx_reg >= total_reg)
                begin
                    if (kind_reg == sat_pkg::KIND_CHECK)
                    begin
                        fire_next  = sec_zero_reg & found_reg;
                        state_next = ST_FINISH;
                    end
                    else if (found_reg)
                    begin
                        status_next = sat_pkg::STAT_DUP;
                        state_next  = ST_FINISH;
                    end
                    else if (total_reg >= sat_pkg::CNT_W'(sat_pkg::MAX_ALARMS))
                    begin
                        status_next = sat_pkg::STAT_FULL;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        ptr_next   = sat_pkg::ADDR_W'(total_reg);
                        state_next = ST_INS_RD;
                    end
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg[sat_pkg::ADDR_W-1:0];
                    state_next    = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP:
            begin
                if (mem_rdata == key_reg)
                begin
                    found_next = 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SCAN_RD;
            end

            // shift larger entries up, walking down from the top
            ST_INS_RD:
            begin
                if (ptr_reg == '0)
                begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = '0;
                    mem_req.wdata = key_reg;
                    total_next    = total_reg + 1'b1;
                    state_next    = ST_FINISH;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg - 1'b1;
                    state_next    = ST_INS_WR;
                end
            end

            ST_INS_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg;
                if (mem_rdata > key_reg)
                begin
                    mem_req.wdata = mem_rdata;
                    ptr_next      = ptr_reg - 1'b1;
                    state_next    = ST_INS_RD;
                end
                else
                begin
                    mem_req.wdata = key_reg;
                    total_next    = total_reg + 1'b1;
                    state_next    = ST_FINISH;
                end
            end

            // close the gap, walking up from the deleted slot
            ST_DEL_RD:
            begin
                if ((ptr_ext + 1'b1) >= total_reg)
                begin
                    total_next = total_reg - 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = ptr_reg + 1'b1;
                    state_next    = ST_DEL_WR;
                end
            end

            ST_DEL_WR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = ptr_reg;
                mem_req.wdata = mem_rdata;
                ptr_next      = ptr_reg + 1'b1;
                state_next    = ST_DEL_RD;
            end

            ST_RD_WAIT:
            begin
                entry_next = mem_rdata;
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        ptr_reg      <= ptr_next;
        found_reg    <= found_next;
        kind_reg     <= kind_next;
        key_reg      <= key_next;
        sec_zero_reg <= sec_zero_next;
        fire_reg     <= fire_next;
        status_reg   <= status_next;
        entry_reg    <= entry_next;
    end

    // outputs
    assign in_ready            = (state_reg == ST_IDLE);
    assign result.valid        = (state_reg == ST_FINISH);
    assign result.fire         = fire_reg;
    assign result.alarm_count  = sat_pkg::COUNT_W'(total_reg);
    assign result.status       = status_reg;
    assign result.entry_hour   = entry_reg[sat_pkg::KEY_W-1:sat_pkg::MINUTE_W];
    assign result.entry_minute = entry_reg[sat_pkg::MINUTE_W-1:0];

    // checks
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= sat_pkg::CNT_W'(sat_pkg::MAX_ALARMS))
        else $error("alarm count above table size");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_req.we && mem_req.re))
        else $error("memory read and write in the same cycle");

    a_total_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (total_reg != $past(total_reg)) |-> (state_reg == ST_FINISH))
        else $error("alarm count changed outside completion");

    a_fire_only_check: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && fire_reg) |-> (kind_reg == sat_pkg::KIND_CHECK))
        else $error("fire raised for a request other than a time check");

endmodule

// File: test/sorted_alarm_time_table_tb.sv
`timescale 1ns / 100ps

module sorted_alarm_time_table_tb;

    import sat_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PHASE_ITEMS    = 420;

    // expected contents of one result
    typedef struct {
        logic                fire;
        logic [COUNT_W-1:0]  alarm_count;
        status_t             status;
        logic [HOUR_W-1:0]   entry_hour;
        logic [MINUTE_W-1:0] entry_minute;
    } alarm_result_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // hour[4:0], minute[10:5], second[16:11], slot[20:17]
    logic [1:0]  s_tuser  = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // fire[0], alarm_count[5:1], status[7:6],
                                  // entry_hour[12:8], entry_minute[18:13]

    // shadow copy of the sorted table
    logic [KEY_W-1:0] shadow_alarms [MAX_ALARMS];
    int               shadow_total = 0;

    alarm_result_t pending_results [$];
    alarm_result_t want_result;

    int fail_count    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_len      = 0;
    int hold_count;

    int requests_sent = 0;
    int alarm_hits    = 0;
    int dup_seen      = 0;
    int full_seen     = 0;
    int bad_seen      = 0;

    sorted_alarm_time_table i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // work out the result of one request and update the shadow table
    function automatic alarm_result_t apply_alarm_request(
        kind_t kind, logic [HOUR_W-1:0] hour, logic [MINUTE_W-1:0] minute,
        logic [SECOND_W-1:0] second, logic [SLOT_W-1:0] slot);
        alarm_result_t    res;
        logic [KEY_W-1:0] key;
        bit               found;
        int               i;
        res.fire         = 1'b0;
        res.status       = STAT_OK;
        res.entry_hour   = '0;
        res.entry_minute = '0;
        key   = {hour, minute};
        found = 1'b0;
        for (i = 0; i < shadow_total; i++)
            if (shadow_alarms[i] == key)
                found = 1'b1;
        case (kind)
            KIND_CHECK:
            begin
                res.fire = (second == '0) && found;
            end
            KIND_INSERT:
            begin
                if (found)
                    res.status = STAT_DUP;
                else if (shadow_total >= MAX_ALARMS)
                    res.status = STAT_FULL;
                else
                begin
                    // open a gap above the larger entries
                    i = shadow_total;
                    while (i > 0 && shadow_alarms[i-1] > key)
                    begin
                        shadow_alarms[i] = shadow_alarms[i-1];
                        i--;
                    end
                    shadow_alarms[i] = key;
                    shadow_total++;
                end
            end
            KIND_DELETE:
            begin
                if (slot >= shadow_total)
                    res.status = STAT_BAD_INDEX;
                else
                begin
                    for (i = slot; i + 1 < shadow_total; i++)
                        shadow_alarms[i] = shadow_alarms[i+1];
                    shadow_total--;
                end
            end
            default:
            begin
                if (slot >= shadow_total)
                    res.status = STAT_BAD_INDEX;
                else
                begin
                    res.entry_hour   = shadow_alarms[slot][KEY_W-1:MINUTE_W];
                    res.entry_minute = shadow_alarms[slot][MINUTE_W-1:0];
                end
            end
        endcase
        res.alarm_count = shadow_total[COUNT_W-1:0];
        return res;
    endfunction

    // offer one request, wait for it to be taken, queue its expected result
    task automatic send_alarm_request(kind_t kind, int hour, int minute, int second, int slot);
        alarm_result_t res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, slot[SLOT_W-1:0], second[SECOND_W-1:0],
                     minute[MINUTE_W-1:0], hour[HOUR_W-1:0]};
        do
            @(posedge clk);
        while (!s_tready);
        res = apply_alarm_request(kind, hour[HOUR_W-1:0], minute[MINUTE_W-1:0],
                                  second[SECOND_W-1:0], slot[SLOT_W-1:0]);
        pending_results.push_back(res);
        requests_sent++;
        if (res.fire)
            alarm_hits++;
        if (res.status == STAT_DUP)
            dup_seen++;
        if (res.status == STAT_FULL)
            full_seen++;
        if (res.status == STAT_BAD_INDEX)
            bad_seen++;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request waiting: m_tdata %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                check_field("fire", want_result.fire, m_tdata[0]);
                check_field("alarm_count", want_result.alarm_count, m_tdata[5:1]);
                check_field("status", want_result.status, m_tdata[7:6]);
                check_field("entry_hour", want_result.entry_hour, m_tdata[12:8]);
                check_field("entry_minute", want_result.entry_minute, m_tdata[18:13]);
            end
        end
    end

    // output side: random stalls, plus a long hold when asked
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_len > 0)
            begin
                hold_count = hold_len;
                hold_len   = 0;
                m_tready <= 1'b0;
                repeat (hold_count) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("FAIL sorted_alarm_time_table");
                $finish;
            end
        end
    end

    // extremes, empty table, duplicates, out of range times, gap closing
    task automatic test_directed_edges();
        send_idle_pct = 0;
        out_stall_pct = 0;
        send_alarm_request(KIND_CHECK,  0,  0,  0,  0);
        send_alarm_request(KIND_READ,   0,  0,  0,  0);
        send_alarm_request(KIND_DELETE, 0,  0,  0, 15);
        send_alarm_request(KIND_INSERT, 23, 59, 0,  0);
        send_alarm_request(KIND_INSERT, 0,  0,  63, 15);
        send_alarm_request(KIND_INSERT, 31, 63, 0,  0);
        send_alarm_request(KIND_INSERT, 23, 59, 0,  0);
        send_alarm_request(KIND_CHECK,  23, 59, 0,  0);
        send_alarm_request(KIND_CHECK,  23, 59, 1,  0);
        send_alarm_request(KIND_CHECK,  31, 63, 63, 15);
        send_alarm_request(KIND_CHECK,  31, 63, 0,  15);
        send_alarm_request(KIND_READ,   0,  0,  0,  2);
        send_alarm_request(KIND_READ,   31, 63, 63, 3);
        send_alarm_request(KIND_DELETE, 0,  0,  0,  1);
        send_alarm_request(KIND_READ,   0,  0,  0,  1);
    endtask

    // fill to the top in descending order, then push past it
    task automatic test_full_table();
        int n;
        for (n = 0; shadow_total < MAX_ALARMS; n++)
            send_alarm_request(KIND_INSERT, 22 - n, 30, 0, 0);
        send_alarm_request(KIND_INSERT, 12, 0, 0, 0);
        send_alarm_request(KIND_INSERT, 23, 59, 0, 0);
        send_alarm_request(KIND_READ,   0, 0, 0, 15);
        send_alarm_request(KIND_DELETE, 0, 0, 0, 15);
        send_alarm_request(KIND_DELETE, 0, 0, 0, 0);
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_stalled_output();
        int n;
        send_idle_pct = 0;
        out_stall_pct = 0;
        hold_len      = LONG_HOLD;
        for (n = 0; n < 10; n++)
            send_alarm_request(KIND_READ, 0, 0, 0, $urandom_range(15));
    endtask

    // random requests, swinging the table between full and empty
    task automatic run_random_phase(int items, int idle_pct, int stall_pct);
        int    n;
        int    roll;
        int    hour;
        int    minute;
        int    second;
        int    slot;
        int    pick;
        bit    filling;
        kind_t kind;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        for (n = 0; n < items; n++)
        begin
            filling = ((n / 50) % 2) == 0;
            roll    = $urandom_range(99);
            if (filling)
                kind = (roll < 50) ? KIND_INSERT : (roll < 80) ? KIND_CHECK :
                       (roll < 85) ? KIND_DELETE : KIND_READ;
            else
                kind = (roll < 10) ? KIND_INSERT : (roll < 35) ? KIND_CHECK :
                       (roll < 80) ? KIND_DELETE : KIND_READ;

            // time fields: mostly legal, some stored times, some full range
            roll   = $urandom_range(99);
            hour   = $urandom_range(23);
            minute = $urandom_range(59);
            if (roll < 15)
            begin
                hour   = $urandom_range(31);
                minute = $urandom_range(63);
            end
            else if (roll < 55 && shadow_total > 0)
            begin
                pick   = $urandom_range(shadow_total - 1);
                hour   = shadow_alarms[pick][KEY_W-1:MINUTE_W];
                minute = shadow_alarms[pick][MINUTE_W-1:0];
            end
            second = ($urandom_range(99) < 60) ? 0 : $urandom_range(63);

            // slot: mostly inside the table
            if (shadow_total > 0 && $urandom_range(99) < 80)
                slot = $urandom_range(shadow_total - 1);
            else
                slot = $urandom_range(15);

            send_alarm_request(kind, hour, minute, second, slot);
        end
    endtask

    // test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_full_table();
        test_stalled_output();
        run_random_phase(PHASE_ITEMS, 0, 0);
        run_random_phase(PHASE_ITEMS, 56, 0);
        run_random_phase(PHASE_ITEMS, 0, 56);
        run_random_phase(PHASE_ITEMS, 24, 24);
        s_tvalid <= 1'b0;

        // let the last results come out
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests: %0d alarm hits, %0d duplicates, %0d full-table",
                 requests_sent, alarm_hits, dup_seen, full_seen);
        $display("inserts and %0d bad indexes, under four idle mixes and one long output hold",
                 bad_seen);
        if (fail_count == 0)
            $display("PASS sorted_alarm_time_table");
        else
            $display("FAIL sorted_alarm_time_table");
        $finish;
    end

endmodule
